FILE: design/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and helper functions for the URI
// percent/UTF-8 decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  // most bytes a single character can produce
  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  // characters with a special meaning
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LC    = 8'h63;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;

  // escape scan phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT,
    PH_CONT
  } phase_e;

  // position inside a continuation group
  typedef enum logic [1:0] {
    POS_SEP,
    POS_FIRST,
    POS_SECOND_HEX,
    POS_SECOND_NONHEX
  } grp_pos_e;

  // decoder state
  typedef struct packed {
    phase_e     phase;
    logic [7:0] held_char;
    logic [1:0] pairs_left;
    grp_pos_e   pos;
    logic [3:0] high_nibble;
  } dec_state_t;

  // one output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       final_result;
    logic       truncated;
  } result_t;

  // words produced by one character
  typedef struct packed {
    logic [CNT_W-1:0]           count;
    result_t [MAX_RES-1:0]      res;
  } dec_list_t;

  // hex digit value, msb set when the character is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  // bytes in the sequence that a lead digit opens, zero if none
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] r;
    r = 3'd0;
    if (c inside {[CH_ZERO:CH_SEVEN]}) begin
      r = 3'd1;
    end else if (c inside {CH_LC, CH_UC, CH_LD, CH_UD}) begin
      r = 3'd2;
    end else if (c inside {CH_LE, CH_UE}) begin
      r = 3'd3;
    end else if (c inside {CH_LF, CH_UF}) begin
      r = 3'd4;
    end
    return r;
  endfunction

  // first escape pair qualifies
  function automatic logic pair_ok(input logic [7:0] x0, input logic [7:0] x1);
    logic [4:0] hv;
    logic       r;
    hv = hex_val(x1);
    if (x0 inside {CH_LC, CH_UC}) begin
      r = (x1 inside {[CH_TWO:CH_NINE]}) || (hv[4] && (hv[3:0] >= 4'd10));
    end else if (x0 inside {CH_LF, CH_UF}) begin
      r = x1 inside {[CH_ZERO:CH_FOUR]};
    end else begin
      r = (lead_len(x0) != 3'd0) && hv[4];
    end
    return r;
  endfunction

  // append one data byte, dropped once the list is full
  function automatic dec_list_t put_byte(input dec_list_t l, input logic [7:0] b);
    dec_list_t r;
    r = l;
    if (l.count < CNT_W'(MAX_RES)) begin
      r.res[l.count] = '{out_byte: b, byte_valid: 1'b1, final_result: 1'b0,
                         truncated: 1'b0};
      r.count = l.count + CNT_W'(1);
    end
    return r;
  endfunction

  // ordinary text character, plus becomes space
  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

FILE: design/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Single-pass decode of one character: from the current state and the
// character, forms the next state and the list of output words.
// ----------------------------------------------------------------------------
module upd_decode (
  input  upd_pkg::dec_state_t st_i,
  input  logic [7:0]          in_char_i,
  input  logic                end_of_text_i,
  output upd_pkg::dec_state_t st_o,
  output upd_pkg::dec_list_t  list_o
);

  always_comb begin
    upd_pkg::dec_state_t st;
    upd_pkg::dec_list_t  l;
    upd_pkg::dec_list_t  lf;
    logic [4:0]          hv;
    logic [4:0]          hx;
    logic [2:0]          len;
    logic                trunc;

    st    = st_i;
    l     = '0;
    hv    = upd_pkg::hex_val(in_char_i);
    hx    = upd_pkg::hex_val(st_i.held_char);
    len   = upd_pkg::lead_len(st_i.held_char);
    trunc = 1'b0;

    // character step
    case (st_i.phase)
      upd_pkg::PH_PCT: begin
        if (upd_pkg::lead_len(in_char_i) != 3'd0) begin
          st.held_char = in_char_i;
          st.phase     = upd_pkg::PH_DIGIT;
        end else begin
          l = upd_pkg::put_byte(l, upd_pkg::CH_PCT);
          if (in_char_i != upd_pkg::CH_PCT) begin
            l        = upd_pkg::put_byte(l, upd_pkg::plain_byte(in_char_i));
            st.phase = upd_pkg::PH_IDLE;
          end
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (upd_pkg::pair_ok(st_i.held_char, in_char_i)) begin
          l = upd_pkg::put_byte(l, {hx[3:0], hv[3:0]});
          if (len <= 3'd1) begin
            st.phase = upd_pkg::PH_IDLE;
          end else begin
            st.pairs_left = 2'(len - 3'd1);
            st.pos        = upd_pkg::POS_SEP;
            st.phase      = upd_pkg::PH_CONT;
          end
        end else begin
          // failed escape: literal percent, held digit, rescan character
          l = upd_pkg::put_byte(l, upd_pkg::CH_PCT);
          l = upd_pkg::put_byte(l, st_i.held_char);
          if (in_char_i == upd_pkg::CH_PCT) begin
            st.phase = upd_pkg::PH_PCT;
          end else begin
            l        = upd_pkg::put_byte(l, upd_pkg::plain_byte(in_char_i));
            st.phase = upd_pkg::PH_IDLE;
          end
        end
      end
      upd_pkg::PH_CONT: begin
        case (st_i.pos)
          upd_pkg::POS_SEP: begin
            st.pos = upd_pkg::POS_FIRST;
          end
          upd_pkg::POS_FIRST: begin
            if (hv[4]) begin
              st.high_nibble = hv[3:0];
              st.pos         = upd_pkg::POS_SECOND_HEX;
            end else begin
              st.high_nibble = 4'd0;
              st.pos         = upd_pkg::POS_SECOND_NONHEX;
            end
          end
          upd_pkg::POS_SECOND_HEX: begin
            if (hv[4]) begin
              l = upd_pkg::put_byte(l, {st_i.high_nibble, hv[3:0]});
            end else begin
              l = upd_pkg::put_byte(l, {4'd0, st_i.high_nibble});
            end
            st.pairs_left = st_i.pairs_left - 2'd1;
            st.pos        = upd_pkg::POS_SEP;
            if (st.pairs_left == 2'd0) begin
              st.phase = upd_pkg::PH_IDLE;
            end
          end
          default: begin
            l             = upd_pkg::put_byte(l, 8'd0);
            st.pairs_left = st_i.pairs_left - 2'd1;
            st.pos        = upd_pkg::POS_SEP;
            if (st.pairs_left == 2'd0) begin
              st.phase = upd_pkg::PH_IDLE;
            end
          end
        endcase
      end
      default: begin
        if (in_char_i == upd_pkg::CH_PCT) begin
          st.phase = upd_pkg::PH_PCT;
        end else begin
          l = upd_pkg::put_byte(l, upd_pkg::plain_byte(in_char_i));
        end
      end
    endcase

    // end of text: flush pending escape, mark last word, back to idle
    lf = l;
    if (end_of_text_i) begin
      if (st.phase == upd_pkg::PH_PCT) begin
        lf = upd_pkg::put_byte(lf, upd_pkg::CH_PCT);
      end else if (st.phase == upd_pkg::PH_DIGIT) begin
        lf = upd_pkg::put_byte(lf, upd_pkg::CH_PCT);
        lf = upd_pkg::put_byte(lf, st.held_char);
      end else if (st.phase == upd_pkg::PH_CONT) begin
        trunc = 1'b1;
      end
      st.phase       = upd_pkg::PH_IDLE;
      st.pairs_left  = 2'd0;
      st.pos         = upd_pkg::POS_SEP;
      st.high_nibble = 4'd0;
      if (lf.count == '0) begin
        lf.count  = upd_pkg::CNT_W'(1);
        lf.res[0] = '{out_byte: 8'd0, byte_valid: 1'b0, final_result: 1'b1,
                      truncated: trunc};
      end else begin
        for (int i = 0; i < upd_pkg::MAX_RES; i++) begin
          if (upd_pkg::CNT_W'(i) == lf.count - upd_pkg::CNT_W'(1)) begin
            lf.res[i].final_result = 1'b1;
            lf.res[i].truncated    = trunc;
          end
        end
      end
    end

    st_o   = st;
    list_o = lf;
  end

endmodule

FILE: design/upd_out_buf.sv
// ----------------------------------------------------------------------------
// upd_out_buf
// Result register for the decoder: holds one character's words and hands
// them out one per unstalled cycle, taking the next list as the last goes.
// ----------------------------------------------------------------------------
module upd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  upd_pkg::dec_list_t list_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output upd_pkg::result_t   word_o
);

  upd_pkg::result_t [upd_pkg::MAX_RES-1:0] ent_q, ent_d;
  logic [upd_pkg::CNT_W-1:0]              cnt_q, cnt_d;
  logic                                   pop;

  // handshake
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == '0) || ((cnt_q == upd_pkg::CNT_W'(1)) && pop);
  assign word_o      = ent_q[0];

  // shift down on pop, reload with a fresh list
  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (pop) begin
      for (int i = 0; i < upd_pkg::MAX_RES - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      cnt_d = cnt_q - upd_pkg::CNT_W'(1);
    end
    if (load_i) begin
      ent_d = list_i.res;
      cnt_d = list_i.count;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a list is only taken once the previous one is gone
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("list loaded while words still pending");

  // more than one pending word blocks new input
  a_busy_not_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > upd_pkg::CNT_W'(1)) |-> !free_o)
    else $error("buffer reports free with several words pending");

  // a pop without load drops the count by one
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i) |=> (cnt_q == $past(cnt_q) - upd_pkg::CNT_W'(1)))
    else $error("word count wrong after pop");

  // the final word of a text is always the last pending one
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && word_o.final_result) |-> (cnt_q == upd_pkg::CNT_W'(1)))
    else $error("final word followed by further words");

endmodule

FILE: design/uri_percent_utf8_decoder.sv
// ----------------------------------------------------------------------------
// uri_percent_utf8_decoder
// Streaming percent decoder for URI text with UTF-8 multi-byte escapes.
// ----------------------------------------------------------------------------
// Takes one character word per cycle while in_stall_o is low and returns
// decoded byte words. Each character is decoded in one pass from the state
// register into a three-word result register, which drains one word per
// cycle while out_stall_i is low. A character that yields more than one
// word (a failed escape gives up to three) holds off input until its last
// word is leaving the result register. Plus decodes to space, %XX escapes
// decode per their lead pair, and the last word of a text carries
// final_result (and truncated when the text ended inside a multi-byte
// escape). A text whose last character yields nothing still gets one bare
// end word with byte_valid low.
module uri_percent_utf8_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       final_result_o,
  output logic       truncated_o
);

  upd_pkg::dec_state_t st_q, st_d, st_next;
  upd_pkg::dec_list_t  list;
  upd_pkg::result_t    word;
  logic                free;
  logic                accept;

  // input handshake
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  // character decode
  upd_decode u_decode (
    .st_i          (st_q),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .st_o          (st_next),
    .list_o        (list)
  );

  // result register
  upd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .list_i      (list),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (word)
  );

  assign out_byte_o     = word.out_byte;
  assign byte_valid_o   = word.byte_valid;
  assign final_result_o = word.final_result;
  assign truncated_o    = word.truncated;

  // state update on accept
  assign st_d = accept ? st_next : st_q;

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= upd_pkg::PH_IDLE;
      st_q.held_char   <= 8'd0;
      st_q.pairs_left  <= 2'd0;
      st_q.pos         <= upd_pkg::POS_SEP;
      st_q.high_nibble <= 4'd0;
    end else begin
      st_q.phase       <= st_d.phase;
      st_q.held_char   <= st_d.held_char;
      st_q.pairs_left  <= st_d.pairs_left;
      st_q.pos         <= st_d.pos;
      st_q.high_nibble <= st_d.high_nibble;
    end
  end

  // end of text always returns the decoder to idle
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_text_i) |=> (st_q.phase == upd_pkg::PH_IDLE))
    else $error("decoder not idle after end of text");

  // continuation phase always has pairs left to take
  a_cont_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == upd_pkg::PH_CONT) |-> (st_q.pairs_left != 2'd0))
    else $error("continuation phase with no pairs left");

  // truncated only marks a final word
  a_trunc_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && truncated_o) |-> final_result_o)
    else $error("truncated flag on a non-final word");

endmodule
